/* src/dpqs_pkg.sv */
`timescale 1ns / 1ps

package dpqs_pkg;

    // Sizing of the two sorted queues and of the stored client identifier.
    localparam int QUEUE_DEPTH = 64;
    localparam int ID_BITS     = 8;

    // Fixed field widths of the command and result transactions.
    localparam int CLIENT_W = 8;
    localparam int URG_W    = 7;
    localparam int DL_W     = 5;
    localparam int COUNT_W  = 7;

    // Only the low ID_BITS bits of an identifier are kept, and never more than the field holds.
    localparam int ID_KEEP = (ID_BITS < CLIENT_W) ? ID_BITS : CLIENT_W;
    localparam int ADDR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        OP_ARRIVE  = 1'b0,
        OP_SERVICE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ACT_IDLE   = 2'd0,
        ACT_FIRST  = 2'd1,
        ACT_SECOND = 2'd2,
        ACT_REJECT = 2'd3
    } action_t;

    typedef struct packed {
        op_t                 opcode;
        logic [CLIENT_W-1:0] client_id;
        logic [URG_W-1:0]    urgency_key;
        logic [DL_W-1:0]     deadline_key;
    } cmd_t;

    typedef struct packed {
        action_t             action;
        logic [CLIENT_W-1:0] served_id;
        logic [COUNT_W-1:0]  first_count;
        logic [COUNT_W-1:0]  second_count;
    } result_t;

    typedef struct packed {
        logic [ID_KEEP-1:0] id;
        logic [URG_W-1:0]   urgency;
        logic [DL_W-1:0]    deadline;
    } first_entry_t;

    typedef struct packed {
        logic [ID_KEEP-1:0] id;
        logic [DL_W-1:0]    deadline;
    } second_entry_t;

    localparam int FIRST_W  = $bits(first_entry_t);
    localparam int SECOND_W = $bits(second_entry_t);

endpackage

/* src/dual_priority_queue_scheduler_unit.sv */
`timescale 1ns / 1ps

// Dual priority queue scheduler: two sorted queues share one server.
// A command transaction is accepted on the rising edge where start is high and
// busy is low. An arrive command inserts the client into the first queue by
// urgency key; a service command grants the head of one queue, moving a client
// granted from the first queue into the second queue by deadline key.
// Each command yields exactly one result transaction: done is high for one
// cycle with the result on the result port. The receiver cannot stall, so the
// result is taken in that cycle and busy falls in the next one.
// After the accepting edge a command steps through dispatch and done for an idle
// service, a rejected arrival or an arrival into an empty queue; dispatch, head
// and done for a second-stage grant or a first-stage grant into an empty second
// queue; dispatch, walk and done for any other arrival; and dispatch, head, walk
// and done for any other first-stage grant. The walk takes one more step per
// entry that the sorted insertion moves up, one entry per cycle on the single
// read and single write port of the queue RAM. One command is in flight at a time
// and the next is accepted in the cycle after done at the earliest.
// Reset clears both fill counts; the queue RAMs need no clearing because
// only entries below the fill counts are ever used.
module dual_priority_queue_scheduler_unit
    import dpqs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    // One-hot sequencer.
    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_HEAD     = 5'b00100,
        S_WALK     = 5'b01000,
        S_DONE     = 5'b10000
    } state_t;

    localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);

    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   first_fill_reg, first_fill_next;
    logic [FILL_W-1:0]   second_fill_reg, second_fill_next;

    // Command and working registers of the current transaction.
    cmd_t                cmd_reg;
    action_t             action_reg, action_next;
    logic [CLIENT_W-1:0] served_reg, served_next;
    first_entry_t        new_reg, new_next;
    logic [URG_W-1:0]    key_reg, key_next;
    logic                sel_second_reg, sel_second_next;
    logic [FILL_W-1:0]   pos_reg, pos_next;
    logic                place_reg, place_next;

    // RAM ports.
    logic                first_we, second_we;
    logic [ADDR_W-1:0]   first_waddr, second_waddr;
    logic [ADDR_W-1:0]   first_raddr, second_raddr;
    first_entry_t        first_wdata, first_rdata;
    second_entry_t       second_wdata, second_rdata;

    // Shared key comparator.
    logic [URG_W-1:0]    cmp_a, cmp_b;
    logic                cmp_lt;

    logic [FILL_W-1:0]   first_last, second_last, pos_last, pos_prev2;
    logic                take_first;

    dpqs_ram #(
        .WIDTH(FIRST_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_first_ram (
        .clk  (clk),
        .we   (first_we),
        .waddr(first_waddr),
        .wdata(first_wdata),
        .raddr(first_raddr),
        .rdata(first_rdata)
    );

    dpqs_ram #(
        .WIDTH(SECOND_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_second_ram (
        .clk  (clk),
        .we   (second_we),
        .waddr(second_waddr),
        .wdata(second_wdata),
        .raddr(second_raddr),
        .rdata(second_rdata)
    );

    assign first_last  = first_fill_reg - FILL_ONE;
    assign second_last = second_fill_reg - FILL_ONE;
    assign pos_last    = pos_reg - FILL_ONE;
    assign pos_prev2   = pos_reg - FILL_W'(2);

    // The comparator serves the head decision and every step of the insertion walk.
    always_comb
    begin
        if (state_reg == S_HEAD)
        begin
            cmp_a = first_rdata.urgency;
            cmp_b = URG_W'(second_rdata.deadline);
        end
        else
        begin
            cmp_a = sel_second_reg ? URG_W'(second_rdata.deadline) : first_rdata.urgency;
            cmp_b = key_reg;
        end
    end

    assign cmp_lt = cmp_a < cmp_b;

    // Serve the first queue when the second is empty, or when the second still has
    // room and the first head's urgency lies below the second head's deadline.
    assign take_first = (first_fill_reg != '0) &&
                        ((second_fill_reg == '0) ||
                         ((second_fill_reg < FILL_FULL) && cmp_lt));

    always_comb
    begin
        state_next       = state_reg;
        first_fill_next  = first_fill_reg;
        second_fill_next = second_fill_reg;
        action_next      = action_reg;
        served_next      = served_reg;
        new_next         = new_reg;
        key_next         = key_reg;
        sel_second_next  = sel_second_reg;
        pos_next         = pos_reg;
        place_next       = 1'b0;

        first_we     = 1'b0;
        second_we    = 1'b0;
        first_waddr  = pos_reg[ADDR_W-1:0];
        second_waddr = pos_reg[ADDR_W-1:0];
        first_wdata  = new_reg;
        second_wdata = '{id: new_reg.id, deadline: new_reg.deadline};
        first_raddr  = pos_last[ADDR_W-1:0];
        second_raddr = pos_last[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                action_next = ACT_IDLE;
                served_next = '0;
                if (cmd_reg.opcode == OP_ARRIVE)
                begin
                    new_next.id       = cmd_reg.client_id[ID_KEEP-1:0];
                    new_next.urgency  = cmd_reg.urgency_key;
                    new_next.deadline = cmd_reg.deadline_key;
                    key_next          = cmd_reg.urgency_key;
                    sel_second_next   = 1'b0;
                    pos_next          = first_fill_reg;
                    if (first_fill_reg >= FILL_FULL)
                    begin
                        action_next = ACT_REJECT;
                        served_next = CLIENT_W'(cmd_reg.client_id[ID_KEEP-1:0]);
                        state_next  = S_DONE;
                    end
                    else if (first_fill_reg == '0)
                    begin
                        first_we        = 1'b1;
                        first_waddr     = '0;
                        first_wdata     = new_next;
                        first_fill_next = FILL_ONE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        first_raddr = first_last[ADDR_W-1:0];
                        state_next  = S_WALK;
                    end
                end
                else if (first_fill_reg == '0 && second_fill_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    first_raddr  = first_last[ADDR_W-1:0];
                    second_raddr = second_last[ADDR_W-1:0];
                    state_next   = S_HEAD;
                end
            end

            S_HEAD:
            begin
                if (take_first)
                begin
                    first_fill_next = first_last;
                    action_next     = ACT_FIRST;
                    served_next     = CLIENT_W'(first_rdata.id);
                    new_next        = first_rdata;
                    key_next        = URG_W'(first_rdata.deadline);
                    sel_second_next = 1'b1;
                    pos_next        = second_fill_reg;
                    if (second_fill_reg == '0)
                    begin
                        second_we        = 1'b1;
                        second_waddr     = '0;
                        second_wdata     = '{id: first_rdata.id, deadline: first_rdata.deadline};
                        second_fill_next = FILL_ONE;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        second_raddr = second_last[ADDR_W-1:0];
                        state_next   = S_WALK;
                    end
                end
                else
                begin
                    second_fill_next = second_last;
                    action_next      = ACT_SECOND;
                    served_next      = CLIENT_W'(second_rdata.id);
                    state_next       = S_DONE;
                end
            end

            S_WALK:
            begin
                if (place_reg)
                begin
                    // The walk reached the bottom; the new entry goes to slot zero.
                    first_we  = !sel_second_reg;
                    second_we = sel_second_reg;
                    if (sel_second_reg)
                    begin
                        second_fill_next = second_fill_reg + FILL_ONE;
                    end
                    else
                    begin
                        first_fill_next = first_fill_reg + FILL_ONE;
                    end
                    state_next = S_DONE;
                end
                else if (cmp_lt)
                begin
                    // Entry below has a smaller key: move it up one slot.
                    first_we     = !sel_second_reg;
                    second_we    = sel_second_reg;
                    first_wdata  = first_rdata;
                    second_wdata = second_rdata;
                    first_raddr  = pos_prev2[ADDR_W-1:0];
                    second_raddr = pos_prev2[ADDR_W-1:0];
                    pos_next     = pos_last;
                    place_next   = (pos_reg == FILL_ONE);
                end
                else
                begin
                    first_we  = !sel_second_reg;
                    second_we = sel_second_reg;
                    if (sel_second_reg)
                    begin
                        second_fill_next = second_fill_reg + FILL_ONE;
                    end
                    else
                    begin
                        first_fill_next = first_fill_reg + FILL_ONE;
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            first_fill_reg  <= '0;
            second_fill_reg <= '0;
            place_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            first_fill_reg  <= first_fill_next;
            second_fill_reg <= second_fill_next;
            place_reg       <= place_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= cmd;
        end
        action_reg     <= action_next;
        served_reg     <= served_next;
        new_reg        <= new_next;
        key_reg        <= key_next;
        sel_second_reg <= sel_second_next;
        pos_reg        <= pos_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    always_comb
    begin
        result.action       = action_reg;
        result.served_id    = served_reg;
        result.first_count  = COUNT_W'(first_fill_reg);
        result.second_count = COUNT_W'(second_fill_reg);
    end

endmodule

/* src/dpqs_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module dpqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
